// ===== sv/rbfl_pkg.sv =====
// Shared types, codes and constants of the ring buffer FIFO/LIFO engine.
package rbfl_pkg;

    localparam int DATA_BITS          = 32;
    localparam int CNT_BITS           = 7;
    localparam int OP_BITS            = 3;
    localparam int DEPTH_DEFAULT      = 64;
    localparam int WORD_BITS_DEFAULT  = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP_FIFO = 3'd1,
        OP_POP_LIFO = 3'd2,
        OP_PEEK     = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_FLUSH    = 3'd5,
        OP_QUERY    = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SIZE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_READ,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [DATA_BITS-1:0] write_data;
        logic [CNT_BITS-1:0]  amount;
    } cmd_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic [1:0]           status;
        logic                 has_data;
        logic                 last;
        logic [CNT_BITS-1:0]  fill_level;
        logic                 is_full;
        logic                 is_empty;
    } rsp_t;

endpackage

// ===== sv/rbfl_store.sv =====
// Word store of the ring buffer: one write port and one registered read port.
module rbfl_store
    import rbfl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int WIDTH = WORD_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ring_buffer_fifo_lifo_engine_core.sv =====
// Top level of the ring buffer engine: sequencer, pointers and result register.
// A command is taken only in the idle state; a decode state follows acceptance.
// Single-result commands then pass to the response state, which waits until the output is free.
// Pops and peeks emit each word through a read state and an emit state, owing to the store's registered read port.
// A burst is emitted in full before the next command is taken.
// Reset clears head and tail pointers, fill count and burst state and sets all slots in use; storage is kept.
module ring_buffer_fifo_lifo_engine_core
    import rbfl_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_BITS-1:0] cfg_data
);

    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int STORE_BITS = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   head_reg, head_next;
    logic [IDX_BITS-1:0]   tail_reg, tail_next;
    logic [IDX_BITS-1:0]   ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   slots_reg, slots_next;
    logic [CNT_BITS-1:0]   burst_rem_reg, burst_rem_next;
    logic                  burst_rej_reg, burst_rej_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [OP_BITS-1:0]    op_reg, op_next;
    logic [CNT_BITS-1:0]   amt_reg, amt_next;
    logic [STORE_BITS-1:0] data_reg, data_next;
    status_t               res_status_reg, res_status_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  out_free;
    logic                  wr_en;
    logic [STORE_BITS-1:0] rd_data;
    logic [CNT_BITS-1:0]   n_clip;
    status_t               push_status;

    logic [IDX_BITS-1:0]   wrap_a;
    logic [CNT_BITS-1:0]   wrap_b;
    logic                  wrap_sub;
    logic [CNT_BITS:0]     wrap_sum;
    logic [IDX_BITS-1:0]   wrap_res;

    rbfl_store #(
        .DEPTH (DEPTH),
        .WIDTH (STORE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (data_reg),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Shared modular adder over the slots in use.
    always_comb
    begin
        if (wrap_sub)
        begin
            wrap_sum = {1'b0, CNT_BITS'(wrap_a)} + {1'b0, slots_reg} - {1'b0, wrap_b};
        end
        else
        begin
            wrap_sum = {1'b0, CNT_BITS'(wrap_a)} + {1'b0, wrap_b};
        end
        if (wrap_sum >= {1'b0, slots_reg})
        begin
            wrap_res = IDX_BITS'(wrap_sum - {1'b0, slots_reg});
        end
        else
        begin
            wrap_res = IDX_BITS'(wrap_sum);
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign n_clip    = (amt_reg > count_reg) ? count_reg : amt_reg;

    always_comb
    begin
        if (amt_reg > slots_reg)
        begin
            push_status = ST_SIZE;
        end
        else if (({1'b0, count_reg} + {1'b0, amt_reg}) > {1'b0, slots_reg})
        begin
            push_status = ST_FULL;
        end
        else
        begin
            push_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        slots_next      = slots_reg;
        burst_rem_next  = burst_rem_reg;
        burst_rej_next  = burst_rej_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        amt_next        = amt_reg;
        data_next       = data_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        wr_en           = 1'b0;
        wrap_a          = head_reg;
        wrap_b          = CNT_BITS'(1);
        wrap_sub        = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_data == '0)
                    begin
                        slots_next = CNT_BITS'(1);
                    end
                    else if (cfg_data > DEPTH_CNT)
                    begin
                        slots_next = DEPTH_CNT;
                    end
                    else
                    begin
                        slots_next = cfg_data;
                    end
                    head_next      = '0;
                    tail_next      = '0;
                    count_next     = '0;
                    burst_rem_next = '0;
                    burst_rej_next = 1'b0;
                end
                if (cmd_valid)
                begin
                    op_next    = cmd.opcode;
                    amt_next   = cmd.amount;
                    data_next  = cmd.write_data[STORE_BITS-1:0];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next      = S_RESP;
                res_status_next = ST_OK;
                if (op_reg != OP_PUSH)
                begin
                    burst_rem_next = '0;
                    burst_rej_next = 1'b0;
                end
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (burst_rem_reg != '0)
                        begin
                            burst_rem_next = burst_rem_reg - CNT_BITS'(1);
                            if (burst_rej_reg)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wrap_a     = tail_reg;
                                tail_next  = wrap_res;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                            if (burst_rem_reg == CNT_BITS'(1))
                            begin
                                burst_rej_next = 1'b0;
                            end
                        end
                        else if (amt_reg == '0)
                        begin
                            res_status_next = ST_SIZE;
                        end
                        else
                        begin
                            res_status_next = push_status;
                            burst_rem_next  = amt_reg - CNT_BITS'(1);
                            burst_rej_next  = (push_status != ST_OK) && (amt_reg != CNT_BITS'(1));
                            if (push_status == ST_OK)
                            begin
                                wr_en      = 1'b1;
                                wrap_a     = tail_reg;
                                tail_next  = wrap_res;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                    end

                    OP_POP_FIFO:
                    begin
                        if (n_clip == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            wrap_a     = head_reg;
                            wrap_b     = n_clip;
                            head_next  = wrap_res;
                            ptr_next   = head_reg;
                            cnt_next   = n_clip;
                            count_next = count_reg - n_clip;
                            state_next = S_READ;
                        end
                    end

                    OP_POP_LIFO:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (n_clip != '0)
                        begin
                            wrap_a     = tail_reg;
                            wrap_b     = n_clip;
                            wrap_sub   = 1'b1;
                            tail_next  = wrap_res;
                            ptr_next   = wrap_res;
                            cnt_next   = n_clip;
                            count_next = count_reg - n_clip;
                            state_next = S_READ;
                        end
                    end

                    OP_PEEK:
                    begin
                        if (amt_reg == '0)
                        begin
                            res_status_next = ST_SIZE;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (amt_reg > count_reg)
                        begin
                            res_status_next = ST_SIZE;
                        end
                        else
                        begin
                            ptr_next   = head_reg;
                            cnt_next   = amt_reg;
                            state_next = S_READ;
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            wrap_a     = head_reg;
                            wrap_b     = n_clip;
                            head_next  = wrap_res;
                            count_next = count_reg - n_clip;
                        end
                    end

                    OP_FLUSH:
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end

                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_next.read_data  = '0;
                    rsp_next.status     = res_status_reg;
                    rsp_next.has_data   = 1'b0;
                    rsp_next.last       = 1'b1;
                    rsp_next.fill_level = count_reg;
                    rsp_next.is_full    = (count_reg == slots_reg);
                    rsp_next.is_empty   = (count_reg == '0);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_READ:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_next.read_data  = DATA_BITS'(rd_data);
                    rsp_next.status     = ST_OK;
                    rsp_next.has_data   = 1'b1;
                    rsp_next.last       = (cnt_reg == CNT_BITS'(1));
                    rsp_next.fill_level = count_reg;
                    rsp_next.is_full    = (count_reg == slots_reg);
                    rsp_next.is_empty   = (count_reg == '0);
                    rsp_valid_next      = 1'b1;
                    cnt_next            = cnt_reg - CNT_BITS'(1);
                    wrap_a              = ptr_reg;
                    ptr_next            = wrap_res;
                    state_next          = (cnt_reg == CNT_BITS'(1)) ? S_IDLE : S_READ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            slots_reg     <= DEPTH_CNT;
            burst_rem_reg <= '0;
            burst_rej_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            slots_reg     <= slots_next;
            burst_rem_reg <= burst_rem_next;
            burst_rej_reg <= burst_rej_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        op_reg         <= op_next;
        amt_reg        <= amt_next;
        data_reg       <= data_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_within_slots: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slots_reg)
        else $error("Fill count exceeds the slots in use.");

    a_no_data_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.has_data |-> rsp_reg.read_data == '0)
        else $error("A result without data carries a non-zero word.");

    a_emit_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> cnt_reg != '0)
        else $error("Emitting with no words left to send.");

    a_cfg_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> count_reg == '0)
        else $error("A register write did not empty the buffer.");

endmodule

// ===== test/tb_ring_buffer_fifo_lifo_engine_core.sv =====
// Self-checking testbench for the ring buffer engine core, driven as a queue and as a stack.
module tb_ring_buffer_fifo_lifo_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rbfl_pkg::*;

    localparam int SLOT_MAX      = DEPTH_DEFAULT;
    localparam int SLOT_IDX_BITS = $clog2(SLOT_MAX);
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS   = 50;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 6;

    localparam logic [OP_BITS-1:0] OP_SPARE = 3'd7;

    localparam logic [CNT_BITS-1:0] SLOT_SETTINGS [PHASES] =
        '{7'd0, 7'd127, 7'd5, 7'd64, 7'd2, 7'd17};

    typedef struct packed {
        cmd_t                word;
        logic                known;
        status_t             st;
        logic [CNT_BITS-1:0] fill;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [25] = '{
        '{'{OP_SPARE,    32'h0000_0000, 7'd0},   1'b1, ST_OK,    7'd0},
        '{'{OP_POP_FIFO, 32'h0000_0000, 7'd3},   1'b1, ST_EMPTY, 7'd0},
        '{'{OP_POP_LIFO, 32'h0000_0000, 7'd2},   1'b1, ST_EMPTY, 7'd0},
        '{'{OP_PEEK,     32'h0000_0000, 7'd0},   1'b1, ST_SIZE,  7'd0},
        '{'{OP_PEEK,     32'h0000_0000, 7'd1},   1'b1, ST_EMPTY, 7'd0},
        '{'{OP_REMOVE,   32'h0000_0000, 7'd1},   1'b1, ST_EMPTY, 7'd0},
        '{'{OP_PUSH,     32'hFFFF_FFFF, 7'd0},   1'b1, ST_SIZE,  7'd0},
        '{'{OP_PUSH,     32'h0000_1234, 7'd127}, 1'b1, ST_SIZE,  7'd0},
        '{'{OP_PUSH,     32'h0000_0005, 7'd0},   1'b1, ST_FULL,  7'd0},
        '{'{OP_QUERY,    32'h0000_0000, 7'd0},   1'b1, ST_OK,    7'd0},
        '{'{OP_PUSH,     32'hFFFF_FFFF, 7'd3},   1'b1, ST_OK,    7'd1},
        '{'{OP_PUSH,     32'h0000_0000, 7'd127}, 1'b1, ST_OK,    7'd2},
        '{'{OP_PUSH,     32'hA5A5_A5A5, 7'd0},   1'b1, ST_OK,    7'd3},
        '{'{OP_PUSH,     32'h5A5A_5A5A, 7'd2},   1'b1, ST_OK,    7'd4},
        '{'{OP_POP_LIFO, 32'h0000_0000, 7'd1},   1'b0, ST_OK,    7'd0},
        '{'{OP_PEEK,     32'h0000_0000, 7'd5},   1'b1, ST_SIZE,  7'd3},
        '{'{OP_PEEK,     32'h0000_0000, 7'd3},   1'b0, ST_OK,    7'd0},
        '{'{OP_POP_FIFO, 32'h0000_0000, 7'd1},   1'b0, ST_OK,    7'd0},
        '{'{OP_POP_FIFO, 32'h0000_0000, 7'd0},   1'b1, ST_EMPTY, 7'd2},
        '{'{OP_POP_LIFO, 32'h0000_0000, 7'd0},   1'b1, ST_OK,    7'd2},
        '{'{OP_REMOVE,   32'h0000_0000, 7'd127}, 1'b1, ST_OK,    7'd0},
        '{'{OP_PUSH,     32'hDEAD_BEEF, 7'd1},   1'b1, ST_OK,    7'd1},
        '{'{OP_PUSH,     32'h0000_0000, 7'd64},  1'b1, ST_FULL,  7'd1},
        '{'{OP_PUSH,     32'hFFFF_FFFF, 7'd64},  1'b1, ST_FULL,  7'd1},
        '{'{OP_FLUSH,    32'h0000_0000, 7'd0},   1'b1, ST_OK,    7'd0}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    cmd_t                cmd       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_BITS-1:0] cfg_data  = '0;

    logic [DATA_BITS-1:0] slot_mem [SLOT_MAX];
    int unsigned          rd_ptr        = 0;
    int unsigned          wr_ptr        = 0;
    int unsigned          words_held    = 0;
    int unsigned          burst_left    = 0;
    int unsigned          slot_limit    = SLOT_MAX;
    bit                   burst_dropped = 1'b0;

    rsp_t        op_results [$];
    rsp_t        ring_results_due [$];
    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned fault_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned slot_writes   = 0;
    int unsigned send_idle_pct = 22;
    int unsigned take_idle_pct = 67;

    ring_buffer_fifo_lifo_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic cmd_t make_word(logic [OP_BITS-1:0] op, logic [DATA_BITS-1:0] d,
                                       logic [CNT_BITS-1:0] amt);
        cmd_t w;
        w.opcode     = op;
        w.write_data = d;
        w.amount     = amt;
        return w;
    endfunction

    function automatic rsp_t word_out(logic [DATA_BITS-1:0] d, status_t s, logic hd);
        rsp_t r;
        r           = '0;
        r.read_data = d;
        r.status    = s;
        r.has_data  = hd;
        return r;
    endfunction

    function automatic int unsigned ring_next(int unsigned idx, int unsigned k);
        return (idx + k) % slot_limit;
    endfunction

    function automatic logic [DATA_BITS-1:0] slot_word(int unsigned idx);
        return slot_mem[SLOT_IDX_BITS'(idx)];
    endfunction

    function automatic void clear_ring();
        rd_ptr        = 0;
        wr_ptr        = 0;
        words_held    = 0;
        burst_left    = 0;
        burst_dropped = 1'b0;
    endfunction

    function automatic void store_word(logic [DATA_BITS-1:0] d);
        slot_mem[SLOT_IDX_BITS'(wr_ptr)] = d;
        wr_ptr                           = ring_next(wr_ptr, 1);
        words_held++;
    endfunction

    function automatic void apply_slot_setting(logic [CNT_BITS-1:0] v);
        if (v == 0)
            slot_limit = 1;
        else if (v > SLOT_MAX)
            slot_limit = SLOT_MAX;
        else
            slot_limit = v;
        clear_ring();
    endfunction

    function automatic void compute_ring_results(cmd_t w);
        int unsigned n;
        int unsigned start;
        status_t     st;
        rsp_t        r;
        op_results.delete();
        if (w.opcode != OP_PUSH)
        begin
            burst_left    = 0;
            burst_dropped = 1'b0;
        end
        case (w.opcode)
            OP_PUSH:
            begin
                if (burst_left != 0)
                begin
                    burst_left--;
                    if (burst_dropped)
                        op_results.push_back(word_out('0, ST_FULL, 1'b0));
                    else
                    begin
                        store_word(w.write_data);
                        op_results.push_back(word_out('0, ST_OK, 1'b0));
                    end
                    if (burst_left == 0)
                        burst_dropped = 1'b0;
                end
                else if (w.amount == 0)
                    op_results.push_back(word_out('0, ST_SIZE, 1'b0));
                else
                begin
                    st = ST_OK;
                    if (w.amount > slot_limit)
                        st = ST_SIZE;
                    else if (words_held + w.amount > slot_limit)
                        st = ST_FULL;
                    burst_left    = w.amount - 1;
                    burst_dropped = (st != ST_OK) && (burst_left != 0);
                    if (st == ST_OK)
                        store_word(w.write_data);
                    op_results.push_back(word_out('0, st, 1'b0));
                end
            end
            OP_POP_FIFO:
            begin
                n = (w.amount > words_held) ? words_held : w.amount;
                if (n == 0)
                    op_results.push_back(word_out('0, ST_EMPTY, 1'b0));
                else
                begin
                    for (int unsigned i = 0; i < n; i++)
                        op_results.push_back(word_out(slot_word(ring_next(rd_ptr, i)),
                                                      ST_OK, 1'b1));
                    rd_ptr     = ring_next(rd_ptr, n);
                    words_held = words_held - n;
                end
            end
            OP_POP_LIFO:
            begin
                n = (w.amount > words_held) ? words_held : w.amount;
                if (words_held == 0)
                    op_results.push_back(word_out('0, ST_EMPTY, 1'b0));
                else if (n == 0)
                    op_results.push_back(word_out('0, ST_OK, 1'b0));
                else
                begin
                    start = (wr_ptr + slot_limit - (n % slot_limit)) % slot_limit;
                    for (int unsigned i = 0; i < n; i++)
                        op_results.push_back(word_out(slot_word(ring_next(start, i)),
                                                      ST_OK, 1'b1));
                    wr_ptr     = start;
                    words_held = words_held - n;
                end
            end
            OP_PEEK:
            begin
                if (w.amount == 0)
                    op_results.push_back(word_out('0, ST_SIZE, 1'b0));
                else if (words_held == 0)
                    op_results.push_back(word_out('0, ST_EMPTY, 1'b0));
                else if (w.amount > words_held)
                    op_results.push_back(word_out('0, ST_SIZE, 1'b0));
                else
                    for (int unsigned i = 0; i < w.amount; i++)
                        op_results.push_back(word_out(slot_word(ring_next(rd_ptr, i)),
                                                      ST_OK, 1'b1));
            end
            OP_REMOVE:
            begin
                if (words_held == 0)
                    op_results.push_back(word_out('0, ST_EMPTY, 1'b0));
                else
                begin
                    n          = (w.amount > words_held) ? words_held : w.amount;
                    rd_ptr     = ring_next(rd_ptr, n);
                    words_held = words_held - n;
                    op_results.push_back(word_out('0, ST_OK, 1'b0));
                end
            end
            OP_FLUSH:
            begin
                clear_ring();
                op_results.push_back(word_out('0, ST_OK, 1'b0));
            end
            default:
                op_results.push_back(word_out('0, ST_OK, 1'b0));
        endcase
        foreach (op_results[i])
        begin
            r            = op_results[i];
            r.last       = (i == op_results.size() - 1);
            r.fill_level = CNT_BITS'(words_held);
            r.is_full    = (words_held == slot_limit);
            r.is_empty   = (words_held == 0);
            op_results[i] = r;
        end
    endfunction

    task automatic send_word(cmd_t w, bit known = 1'b0, status_t known_st = ST_OK,
                             logic [CNT_BITS-1:0] known_fill = '0);
        int unsigned gap;
        rsp_t        r;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= w;
        do @(posedge clk); while (!cmd_ready);
        words_sent++;
        compute_ring_results(w);
        if (known)
        begin
            r            = word_out('0, known_st, 1'b0);
            r.last       = 1'b1;
            r.fill_level = known_fill;
            r.is_full    = (known_fill == slot_limit);
            r.is_empty   = (known_fill == 0);
            ring_results_due.push_back(r);
        end
        else
            foreach (op_results[i])
                ring_results_due.push_back(op_results[i]);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (ring_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_slots(logic [CNT_BITS-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        apply_slot_setting(v);
        slot_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_action();
        int unsigned        pick;
        int unsigned        n;
        int unsigned        k;
        int unsigned        room;
        logic [OP_BITS-1:0] op;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            room = slot_limit - words_held;
            case ($urandom_range(9))
                0:       n = (room == 0) ? 1 : room;
                1:       n = $urandom_range(127);
                default: n = $urandom_range((slot_limit < 8) ? slot_limit : 8, 1);
            endcase
            if (n > slot_limit || (n > 1 && $urandom_range(9) == 0))
                k = $urandom_range(3, 1);
            else
                k = (n == 0) ? 1 : n;
            for (int unsigned i = 0; i < k; i++)
                send_word(make_word(OP_PUSH, $urandom,
                                    (i == 0) ? CNT_BITS'(n) : CNT_BITS'($urandom_range(127))));
        end
        else
        begin
            if (pick < 55)
                op = OP_POP_FIFO;
            else if (pick < 67)
                op = OP_POP_LIFO;
            else if (pick < 77)
                op = OP_PEEK;
            else if (pick < 85)
                op = OP_REMOVE;
            else if (pick < 90)
                op = OP_QUERY;
            else if (pick < 93)
                op = OP_SPARE;
            else if (pick < 96)
                op = OP_FLUSH;
            else
                op = OP_BITS'($urandom_range(7));
            n = (pick >= 96) ? $urandom_range(127) : $urandom_range(words_held + 2);
            send_word(make_word(op, $urandom, CNT_BITS'(n)));
        end
    endtask

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk)
    begin
        rsp_t due;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            words_checked++;
            if (ring_results_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: unexpected response word, data %h status %0d",
                             $realtime, rsp.read_data, rsp.status);
            end
            else
            begin
                due = ring_results_due.pop_front();
                if (rsp !== due)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                    begin
                        $display("%0t: expected %h st %0d hd %b last %b fill %0d full %b empty %b",
                                 $realtime, due.read_data, due.status, due.has_data, due.last,
                                 due.fill_level, due.is_full, due.is_empty);
                        $display("%0t: actual   %h st %0d hd %b last %b fill %0d full %b empty %b",
                                 $realtime, rsp.read_data, rsp.status, rsp.has_data, rsp.last,
                                 rsp.fill_level, rsp.is_full, rsp.is_empty);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles, %0d response words still awaited.",
                     cycle_count, ring_results_due.size());
            $display("FAIL ring_buffer_fifo_lifo_engine_core");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_start;
        bit          paused;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED_PLAN[i])
            send_word(DIRECTED_PLAN[i].word, DIRECTED_PLAN[i].known,
                      DIRECTED_PLAN[i].st, DIRECTED_PLAN[i].fill);
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            if (p == 2)
            begin
                send_idle_pct = 67;
                take_idle_pct = 22;
            end
            if (p == 4)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            write_slots(SLOT_SETTINGS[p]);
            phase_start = words_sent;
            paused      = 1'b0;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if (!paused && words_sent - phase_start >= PHASE_WORDS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                send_random_action();
            end
        end
        drain_results();
        $display("Sent %0d command words, checked %0d response words, %0d slot settings,",
                 words_sent, words_checked, slot_writes + 1);
        $display("queue and stack drains, rejected bursts and stalls covered; %0d faults.",
                 fault_count);
        if (fault_count == 0 && ring_results_due.size() == 0)
            $display("PASS ring_buffer_fifo_lifo_engine_core");
        else
            $display("FAIL ring_buffer_fifo_lifo_engine_core");
        $finish;
    end

endmodule
